@@ src/mkf_pkg.sv @@
// Shared types, model coefficients and fixed-point helpers for the motor Kalman filter.
package mkf_pkg;

  localparam int W    = 32;
  localparam int NW   = 31;
  localparam int AW   = 40;
  localparam int FRAC = 28;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_Q_POS  = 3'd0;
  localparam logic [2:0] REG_Q_VEL  = 3'd1;
  localparam logic [2:0] REG_Q_LOAD = 3'd2;
  localparam logic [2:0] REG_Q_CUR  = 3'd3;
  localparam logic [2:0] REG_R_MEAS = 3'd4;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_INIT, OP_MUL, OP_ACC, OP_STORE,
    OP_DIV, OP_KSTORE, OP_INNOV, OP_OUT
  } op_t;

  // Phases of one filter step
  typedef enum logic [2:0] {
    SG_XP, SG_AP, SG_PP, SG_XU, SG_PU
  } stage_t;

  typedef struct packed {
    op_t        op;
    stage_t     stage;
    logic [1:0] i;
    logic [1:0] j;
    logic [2:0] m;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } stat_t;

  // Transition matrix A, Q4.28
  function automatic logic signed [W-1:0] a_coef(input logic [1:0] r, input logic [1:0] c);
    logic signed [W-1:0] v;
    case ({r, c})
      4'b0000: v = 32'sd268435456;
      4'b0001: v = 32'sd53687;
      4'b0011: v = 32'sd26844;
      4'b0101: v = 32'sd227982233;
      4'b0110: v = -32'sd51620138;
      4'b0111: v = 32'sd140525961;
      4'b1010: v = 32'sd268435456;
      4'b1101: v = -32'sd126272039;
      4'b1110: v = 32'sd13475460;
      4'b1111: v = 32'sd194723080;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Input vector B, Q4.28
  function automatic logic signed [W-1:0] b_coef(input logic [1:0] r);
    logic signed [W-1:0] v;
    case (r)
      2'd1:    v = 32'sd6710886;
      2'd3:    v = 32'sd21528524;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Product scaled down by 2^28, rounding half up
  function automatic logic signed [35:0] rnd28(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd134217728;
    return t[63:28];
  endfunction

  function automatic logic signed [W-1:0] sat32(input logic signed [AW-1:0] v);
    logic signed [W-1:0] r;
    if (v > 40'sd2147483647)       r = 32'sh7fffffff;
    else if (v < -40'sd2147483648) r = 32'sh80000000;
    else                           r = v[W-1:0];
    return r;
  endfunction

endpackage

@@ src/motor_kalman_filter_4state_unit.sv @@
// Top level of the four-state motor Kalman filter.
// One item (drive voltage, measured position, Q16.16) runs one full predict and correct
// step and gives one item with the four updated estimates. Every product of the prediction
// and correction goes through a single 32x32 multiplier, and the four gains come from a
// bit-serial divider, one gain after the other. A new item is taken once the previous step
// has handed its result to the output register. The user writes the noise registers
// through the cfg port only while the block is idle; the block itself does not enforce
// this. Reset clears the state to zero and the covariance to the identity.
module motor_kalman_filter_4state_unit import mkf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [NW-1:0]       cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [W-1:0] in_drive_voltage,
  input  logic signed [W-1:0] in_measured_position,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [W-1:0] out_position_estimate,
  output logic signed [W-1:0] out_velocity_estimate,
  output logic signed [W-1:0] out_load_estimate,
  output logic signed [W-1:0] out_current_estimate
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  mkf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  mkf_datapath u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .cfg_we                (cfg_valid),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .in_drive_voltage      (in_drive_voltage),
    .in_measured_position  (in_measured_position),
    .out_position_estimate (out_position_estimate),
    .out_velocity_estimate (out_velocity_estimate),
    .out_load_estimate     (out_load_estimate),
    .out_current_estimate  (out_current_estimate)
  );

endmodule

@@ src/mkf_div.sv @@
// Iterative restoring divider producing the saturated Q4.28 Kalman gain.
module mkf_div import mkf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [W-1:0] num,
  input  logic signed [W:0]   den,
  output logic                done,
  output logic signed [W-1:0] quot
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [5:0]        cnt_r;
  logic [W:0]        rem_r;
  logic [59:0]       qt_r;
  logic [W:0]        dmag_r;
  logic              neg_r;
  logic signed [W-1:0] res_r;

  logic [W-1:0]      nmag;
  logic [W:0]        dmag;
  logic [W+1:0]      shifted;
  logic [W+2:0]      diff;

  assign nmag    = num[W-1] ? W'(-num) : W'(num);
  assign dmag    = den[W] ? (W+1)'(-den) : (W+1)'(den);
  assign shifted = {rem_r, qt_r[59]};
  assign diff    = {1'b0, shifted} - {2'b00, dmag_r};

  // Control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = (den != '0);
      done_nxt = (den == '0);
    end else if (busy_r && cnt_r == '0) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath: one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r  <= 6'd60;
      rem_r  <= '0;
      qt_r   <= {nmag, 28'b0};
      dmag_r <= dmag;
      neg_r  <= num[W-1] ^ den[W];
      if (den == '0) begin
        if (num > 0)      res_r <= 32'sh7fffffff;
        else if (num < 0) res_r <= 32'sh80000000;
        else              res_r <= '0;
      end
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - 6'd1;
        if (!diff[W+2]) begin
          rem_r <= diff[W:0];
          qt_r  <= {qt_r[58:0], 1'b1};
        end else begin
          rem_r <= shifted[W:0];
          qt_r  <= {qt_r[58:0], 1'b0};
        end
      end else begin
        if (neg_r) begin
          if (qt_r > 60'd2147483648) res_r <= 32'sh80000000;
          else                       res_r <= -$signed(qt_r[W-1:0]);
        end else begin
          if (qt_r > 60'd2147483647) res_r <= 32'sh7fffffff;
          else                       res_r <= $signed(qt_r[W-1:0]);
        end
      end
    end
  end

  assign done = done_r;
  assign quot = res_r;

endmodule

@@ src/mkf_datapath.sv @@
// Filter datapath: state and covariance storage, shared multiply-accumulate, gain divider.
module mkf_datapath import mkf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output stat_t               stat,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [NW-1:0]       cfg_data,
  input  logic signed [W-1:0] in_drive_voltage,
  input  logic signed [W-1:0] in_measured_position,
  output logic signed [W-1:0] out_position_estimate,
  output logic signed [W-1:0] out_velocity_estimate,
  output logic signed [W-1:0] out_load_estimate,
  output logic signed [W-1:0] out_current_estimate
);

  logic [NW-1:0]       q_r [4];
  logic [NW-1:0]       r_r;
  logic signed [W-1:0] x_r [4];
  logic signed [W-1:0] p_r [16];
  logic signed [W-1:0] xp_r [4];
  logic signed [W-1:0] ap_r [16];
  logic signed [W-1:0] pp_r [16];
  logic signed [W-1:0] k_r [4];
  logic signed [W-1:0] v_r, z_r, innov_r;
  logic signed [63:0]  prod_r;
  logic signed [AW-1:0] acc_r;
  logic signed [W-1:0] o_r [4];

  logic [3:0]           pp_addr;
  logic signed [W-1:0]  pp_rd;
  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [AW-1:0] init_v, term, acc_nxt;
  logic signed [W-1:0]  res;
  logic signed [W:0]    den;
  logic signed [W:0]    innov_w;
  logic                 div_done;
  logic signed [W-1:0]  div_q;

  // Covariance prediction is read one entry a cycle
  always_comb begin
    if (cmd.stage == SG_PU) pp_addr = (cmd.op == OP_INIT) ? {cmd.i, cmd.j} : {2'b00, cmd.j};
    else                    pp_addr = {cmd.i, 2'b00};
  end
  assign pp_rd = pp_r[pp_addr];

  // Multiplier operands and accumulator start value per phase
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    init_v = '0;
    case (cmd.stage)
      SG_XP: begin
        if (cmd.m[2]) begin
          mul_a = b_coef(cmd.i);
          mul_b = v_r;
        end else begin
          mul_a = a_coef(cmd.i, cmd.m[1:0]);
          mul_b = x_r[cmd.m[1:0]];
        end
      end
      SG_AP: begin
        mul_a = a_coef(cmd.i, cmd.m[1:0]);
        mul_b = p_r[{cmd.m[1:0], cmd.j}];
      end
      SG_PP: begin
        mul_a = ap_r[{cmd.i, cmd.m[1:0]}];
        mul_b = a_coef(cmd.j, cmd.m[1:0]);
        if (cmd.i == cmd.j) init_v = AW'({1'b0, q_r[cmd.i]});
      end
      SG_XU: begin
        mul_a  = k_r[cmd.i];
        mul_b  = innov_r;
        init_v = AW'(xp_r[cmd.i]);
      end
      SG_PU: begin
        mul_a  = k_r[cmd.i];
        mul_b  = pp_rd;
        init_v = AW'(pp_rd);
      end
      default: ;
    endcase
  end

  assign term    = AW'(rnd28(prod_r));
  assign acc_nxt = (cmd.stage == SG_PU) ? acc_r - term : acc_r + term;
  assign res     = sat32(acc_r);
  assign den     = (W+1)'(pp_r[0]) + $signed({2'b00, r_r});
  assign innov_w = (W+1)'(z_r) - (W+1)'(xp_r[0]);

  mkf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == OP_DIV),
    .num   (pp_rd),
    .den   (den),
    .done  (div_done),
    .quot  (div_q)
  );

  assign stat.div_done = div_done;

  // Filter state, covariance and noise registers; reset clears state and noise, covariance to identity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < 4; n++) begin
        q_r[n] <= '0;
        x_r[n] <= '0;
      end
      r_r <= '0;
      for (int n = 0; n < 16; n++) p_r[n] <= (n % 5 == 0) ? 32'sd268435456 : '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_Q_POS:  q_r[0] <= cfg_data;
          REG_Q_VEL:  q_r[1] <= cfg_data;
          REG_Q_LOAD: q_r[2] <= cfg_data;
          REG_Q_CUR:  q_r[3] <= cfg_data;
          REG_R_MEAS: r_r    <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_STORE && cmd.stage == SG_XU) x_r[cmd.i] <= res;
      if (cmd.op == OP_STORE && cmd.stage == SG_PU) p_r[{cmd.i, cmd.j}] <= res;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        v_r <= in_drive_voltage;
        z_r <= in_measured_position;
      end
      OP_INIT: acc_r  <= init_v;
      OP_MUL:  prod_r <= 64'(mul_a) * 64'(mul_b);
      OP_ACC:  acc_r  <= acc_nxt;
      OP_STORE: begin
        case (cmd.stage)
          SG_XP:   xp_r[cmd.i] <= res;
          SG_AP:   ap_r[{cmd.i, cmd.j}] <= res;
          SG_PP:   pp_r[{cmd.i, cmd.j}] <= res;
          default: ;
        endcase
      end
      OP_KSTORE: k_r[cmd.i] <= div_q;
      OP_INNOV:  innov_r <= sat32(AW'(innov_w));
      OP_OUT: begin
        for (int n = 0; n < 4; n++) o_r[n] <= x_r[n];
      end
      default: ;
    endcase
  end

  assign out_position_estimate = o_r[0];
  assign out_velocity_estimate = o_r[1];
  assign out_load_estimate     = o_r[2];
  assign out_current_estimate  = o_r[3];

endmodule

@@ src/mkf_ctrl.sv @@
// Sequencer that walks the datapath through prediction, gain and correction.
module mkf_ctrl import mkf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output cmd_t  cmd,
  input  stat_t stat
);

  typedef enum logic [3:0] {
    C_IDLE, C_INIT, C_MUL, C_ACC, C_STORE, C_DIV, C_DWAIT, C_INNOV, C_OUT
  } state_t;

  state_t     state_r, state_nxt;
  stage_t     stage_r, stage_nxt;
  logic [1:0] i_r, i_nxt, j_r, j_nxt;
  logic [2:0] m_r, m_nxt, last_m;
  logic       ov_r, ov_nxt;
  logic       two_d, elem_last;

  always_comb begin
    case (stage_r)
      SG_XP:        last_m = 3'd4;
      SG_AP, SG_PP: last_m = 3'd3;
      default:      last_m = 3'd0;
    endcase
  end
  assign two_d     = (stage_r == SG_AP) || (stage_r == SG_PP) || (stage_r == SG_PU);
  assign elem_last = two_d ? (i_r == 2'd3 && j_r == 2'd3) : (i_r == 2'd3);

  // Command to the datapath
  always_comb begin
    cmd.stage = stage_r;
    cmd.i     = i_r;
    cmd.j     = j_r;
    cmd.m     = m_r;
    case (state_r)
      C_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_NOP;
      C_INIT:  cmd.op = OP_INIT;
      C_MUL:   cmd.op = OP_MUL;
      C_ACC:   cmd.op = OP_ACC;
      C_STORE: cmd.op = OP_STORE;
      C_DIV:   cmd.op = OP_DIV;
      C_DWAIT: cmd.op = stat.div_done ? OP_KSTORE : OP_NOP;
      C_INNOV: cmd.op = OP_INNOV;
      C_OUT:   cmd.op = (!ov_r || out_ready) ? OP_OUT : OP_NOP;
      default: cmd.op = OP_NOP;
    endcase
  end

  // Next state and counters
  always_comb begin
    state_nxt = state_r;
    stage_nxt = stage_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    m_nxt     = m_r;
    ov_nxt    = ov_r && !out_ready;
    case (state_r)
      C_IDLE: begin
        if (in_valid) begin
          stage_nxt = SG_XP;
          i_nxt     = '0;
          j_nxt     = '0;
          m_nxt     = '0;
          state_nxt = C_INIT;
        end
      end
      C_INIT: state_nxt = C_MUL;
      C_MUL:  state_nxt = C_ACC;
      C_ACC: begin
        if (m_r == last_m) state_nxt = C_STORE;
        else begin
          m_nxt     = m_r + 3'd1;
          state_nxt = C_MUL;
        end
      end
      C_STORE: begin
        m_nxt = '0;
        if (!elem_last) begin
          if (two_d) {i_nxt, j_nxt} = {i_r, j_r} + 4'd1;
          else       i_nxt = i_r + 2'd1;
          state_nxt = C_INIT;
        end else begin
          i_nxt = '0;
          j_nxt = '0;
          case (stage_r)
            SG_XP: begin stage_nxt = SG_AP; state_nxt = C_INIT; end
            SG_AP: begin stage_nxt = SG_PP; state_nxt = C_INIT; end
            SG_PP: state_nxt = C_DIV;
            SG_XU: begin stage_nxt = SG_PU; state_nxt = C_INIT; end
            default: state_nxt = C_OUT;
          endcase
        end
      end
      C_DIV: state_nxt = C_DWAIT;
      C_DWAIT: begin
        if (stat.div_done) begin
          if (i_r == 2'd3) state_nxt = C_INNOV;
          else begin
            i_nxt     = i_r + 2'd1;
            state_nxt = C_DIV;
          end
        end
      end
      C_INNOV: begin
        stage_nxt = SG_XU;
        i_nxt     = '0;
        state_nxt = C_INIT;
      end
      C_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          state_nxt = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      stage_r <= SG_XP;
      i_r     <= '0;
      j_r     <= '0;
      m_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stage_r <= stage_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      m_r     <= m_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_ready  = (state_r == C_IDLE);
  assign out_valid = ov_r;

  // Checks
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while a step runs");
  a_gain_wait: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> state_r == C_DWAIT)
    else $error("gain ready outside the gain wait");
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r) == C_OUT)
    else $error("result raised outside the output step");

endmodule
